/* sv/counting_semaphore_table_core_macros.svh */
// Assertion macros shared by the semaphore table RTL.
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CST_ASSERT_SAME(lbl, ante, cons, msg)
`define CST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/cst_pkg.sv */
// Types, codes and default sizes for the counting semaphore table.
`default_nettype none
package cst_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned ID_W    = 5;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned PID_W   = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  localparam int unsigned NUM_SEMS_DEF    = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned PID_BITS_DEF    = 16;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN  = 3'd0,
    OP_CLOSE = 3'd1,
    OP_POST  = 3'd2,
    OP_WAIT  = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ALREADY = 2'd1,
    ST_BAD     = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    status_e            status;
    logic               must_block;
    logic               wake_valid;
    logic [PID_W-1:0]   wake_pid;
    logic [COUNT_W-1:0] count_value;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

/* sv/counting_semaphore_table_core.sv */
// Counting semaphore table with a FIFO wait queue per entry.
//
// Requests arrive on the input channel (in_valid_i / in_stall_o) and each beat carries an
// operation, a semaphore id, an initial count and the caller's pid. Results leave on the
// output channel (out_valid_o / out_stall_i); last_o marks the final result of a request.
// Each well-formed request reads its table entry from a synchronous memory and writes it
// back if it changes; one request is handled at a time and in_stall_o is high while busy.
// Open, wait, read, a post with no waiter and every rejected request load their result
// from the lookup state that follows the request beat, and the next request can be taken
// while that result is on the output. A post that wakes a waiter passes through a pop
// state as well, because the waiter's pid is read from the queue memory after the entry.
// Close gives one result per queued waiter, oldest first, one per cycle while the
// receiver does not stall, then a final result.
// The result sits in an output register; while the receiver stalls, the block holds
// that beat and waits before it writes the next one.
// Reset clears every entry to closed with a zero count through one valid flag per
// entry; no clearing pass is needed. Queue slots hold nothing defined until written.
`default_nettype none
`include "counting_semaphore_table_core_macros.svh"
module counting_semaphore_table_core #(
  parameter int unsigned NUM_SEMS    = cst_pkg::NUM_SEMS_DEF,
  parameter int unsigned QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned PID_BITS    = cst_pkg::PID_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [cst_pkg::OP_W-1:0]    operation_i,
  input  wire logic [cst_pkg::ID_W-1:0]    sem_id_i,
  input  wire logic [cst_pkg::COUNT_W-1:0] init_count_i,
  input  wire logic [cst_pkg::PID_W-1:0]   caller_pid_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       status_o,
  output logic                             must_block_o,
  output logic                             wake_valid_o,
  output logic [cst_pkg::PID_W-1:0]        wake_pid_o,
  output logic [cst_pkg::COUNT_W-1:0]      count_value_o,
  output logic                             last_o
);

  localparam int unsigned SEM_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int unsigned ID_EXT_W = ((SEM_W > cst_pkg::ID_W) ? SEM_W : cst_pkg::ID_W) + 1;
  localparam int unsigned HEAD_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W    = FILL_W + 1;
  localparam int unsigned WQ_AW    = SEM_W + HEAD_W;
  localparam int unsigned WQ_DEPTH = 1 << WQ_AW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  typedef struct packed {
    logic                        is_open;
    logic [cst_pkg::COUNT_W-1:0] count;
    logic [HEAD_W-1:0]           head;
    logic [FILL_W-1:0]           fill;
  } entry_t;

  function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
    logic [HEAD_W-1:0] r;
    if (h == HEAD_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = h + HEAD_W'(1);
    end
    return r;
  endfunction

  logic [2:0] state_q, state_d;

  // Request registers.
  logic [cst_pkg::OP_W-1:0]    op_q;
  logic [SEM_W-1:0]            idx_q;
  logic                        bad_q;
  logic [cst_pkg::COUNT_W-1:0] init_q;
  logic [PID_BITS-1:0]         pid_q;

  // Close walk and post bookkeeping.
  logic [HEAD_W-1:0]           walk_head_q, walk_head_d;
  logic [FILL_W-1:0]           walk_left_q, walk_left_d;
  logic [cst_pkg::COUNT_W-1:0] cnt_q, cnt_d;

  // Entry table.
  entry_t                tab_mem [NUM_SEMS];
  entry_t                tab_rdata_q;
  logic                  tab_hit_q;
  logic [NUM_SEMS-1:0]   tab_vld_q;
  logic                  tab_re, tab_we;
  entry_t                tab_wdata;
  entry_t                ent;

  // Waiter queues.
  logic [PID_BITS-1:0]   wq_mem [WQ_DEPTH];
  logic [PID_BITS-1:0]   wq_rdata_q;
  logic                  wq_re, wq_we;
  logic [WQ_AW-1:0]      wq_raddr, wq_waddr;

  // Output register.
  logic                  out_valid_q;
  cst_pkg::result_t      res_q, res_d;
  logic                  out_load, out_free;

  // Accept side.
  logic                  in_acc;
  logic [ID_EXT_W-1:0]   id_ext;
  logic [SEM_W-1:0]      rd_idx;
  logic                  bad_d;

  logic [SUM_W-1:0]      tail_sum;
  logic [HEAD_W-1:0]     tail;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign id_ext     = ID_EXT_W'(sem_id_i);
  assign rd_idx     = id_ext[SEM_W-1:0];
  assign bad_d      = (operation_i > cst_pkg::OP_W'(cst_pkg::OP_READ)) ||
                      (sem_id_i == '0) || (id_ext >= ID_EXT_W'(NUM_SEMS));

  // An entry never written since reset reads as closed with everything zero.
  assign ent = tab_hit_q ? tab_rdata_q : '0;

  assign out_free = !out_valid_q || !out_stall_i;

  // Free slot behind the queue: head plus fill, wrapped once.
  assign tail_sum = SUM_W'(ent.head) + SUM_W'(ent.fill);
  assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);

  always_comb begin
    state_d     = state_q;
    walk_head_d = walk_head_q;
    walk_left_d = walk_left_q;
    cnt_d       = cnt_q;
    tab_re      = 1'b0;
    tab_we      = 1'b0;
    tab_wdata   = ent;
    wq_re       = 1'b0;
    wq_we       = 1'b0;
    wq_raddr    = {idx_q, ent.head};
    wq_waddr    = {idx_q, tail};
    out_load    = 1'b0;
    res_d       = '0;
    res_d.status = cst_pkg::ST_OK;
    res_d.last  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          tab_re  = !bad_d;
          state_d = S_LOOK;
        end
      end

      S_LOOK: begin
        if (bad_q) begin
          if (out_free) begin
            out_load     = 1'b1;
            res_d.status = cst_pkg::ST_BAD;
            state_d      = S_IDLE;
          end
        end else if ((op_q != cst_pkg::OP_OPEN) && !ent.is_open) begin
          if (out_free) begin
            out_load     = 1'b1;
            res_d.status = cst_pkg::ST_BAD;
            state_d      = S_IDLE;
          end
        end else begin
          unique case (op_q)
            cst_pkg::OP_OPEN: begin
              if (out_free) begin
                out_load = 1'b1;
                state_d  = S_IDLE;
                if (ent.is_open) begin
                  res_d.status      = cst_pkg::ST_ALREADY;
                  res_d.count_value = ent.count;
                end else begin
                  tab_we            = 1'b1;
                  tab_wdata         = '0;
                  tab_wdata.is_open = 1'b1;
                  tab_wdata.count   = init_q;
                  res_d.count_value = init_q;
                end
              end
            end

            cst_pkg::OP_CLOSE: begin
              if (ent.fill == '0) begin
                state_d = S_FINAL;
              end else begin
                wq_re       = 1'b1;
                walk_head_d = head_inc(ent.head);
                walk_left_d = ent.fill;
                state_d     = S_WALK;
              end
            end

            cst_pkg::OP_POST: begin
              if (ent.fill != '0) begin
                // The waiter's pid arrives next cycle; the entry is updated now.
                wq_re          = 1'b1;
                tab_we         = 1'b1;
                tab_wdata.head = head_inc(ent.head);
                tab_wdata.fill = ent.fill - FILL_W'(1);
                cnt_d          = ent.count;
                state_d        = S_POP;
              end else if (out_free) begin
                tab_we = 1'b1;
                if (ent.count != cst_pkg::COUNT_MAX) begin
                  tab_wdata.count = ent.count + cst_pkg::COUNT_W'(1);
                end
                out_load          = 1'b1;
                res_d.count_value = tab_wdata.count;
                state_d           = S_IDLE;
              end
            end

            cst_pkg::OP_WAIT: begin
              if (out_free) begin
                out_load = 1'b1;
                state_d  = S_IDLE;
                if (ent.count != '0) begin
                  tab_we            = 1'b1;
                  tab_wdata.count   = ent.count - cst_pkg::COUNT_W'(1);
                  res_d.count_value = tab_wdata.count;
                end else if (ent.fill >= FILL_W'(QUEUE_DEPTH)) begin
                  res_d.status = cst_pkg::ST_FULL;
                end else begin
                  wq_we            = 1'b1;
                  tab_we           = 1'b1;
                  tab_wdata.fill   = ent.fill + FILL_W'(1);
                  res_d.must_block = 1'b1;
                end
              end
            end

            default: begin
              if (out_free) begin
                out_load          = 1'b1;
                res_d.count_value = ent.count;
                state_d           = S_IDLE;
              end
            end
          endcase
        end
      end

      S_POP: begin
        if (out_free) begin
          out_load          = 1'b1;
          res_d.wake_valid  = 1'b1;
          res_d.wake_pid    = cst_pkg::PID_W'(wq_rdata_q);
          res_d.count_value = cnt_q;
          state_d           = S_IDLE;
        end
      end

      S_WALK: begin
        wq_raddr = {idx_q, walk_head_q};
        if (out_free) begin
          out_load         = 1'b1;
          res_d.wake_valid = 1'b1;
          res_d.wake_pid   = cst_pkg::PID_W'(wq_rdata_q);
          res_d.last       = 1'b0;
          if (walk_left_q > FILL_W'(1)) begin
            wq_re       = 1'b1;
            walk_head_d = head_inc(walk_head_q);
            walk_left_d = walk_left_q - FILL_W'(1);
          end else begin
            state_d = S_FINAL;
          end
        end
      end

      S_FINAL: begin
        if (out_free) begin
          out_load  = 1'b1;
          tab_we    = 1'b1;
          tab_wdata = '0;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tab_vld_q   <= '0;
      tab_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (tab_we) begin
        tab_vld_q[idx_q] <= 1'b1;
      end
      if (tab_re) begin
        tab_hit_q <= tab_vld_q[rd_idx];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= operation_i;
      idx_q  <= rd_idx;
      bad_q  <= bad_d;
      init_q <= init_count_i;
      pid_q  <= caller_pid_i[PID_BITS-1:0];
    end
    walk_head_q <= walk_head_d;
    walk_left_q <= walk_left_d;
    cnt_q       <= cnt_d;
    if (out_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_re) begin
      tab_rdata_q <= tab_mem[rd_idx];
    end
    if (tab_we) begin
      tab_mem[idx_q] <= tab_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wq_re) begin
      wq_rdata_q <= wq_mem[wq_raddr];
    end
    if (wq_we) begin
      wq_mem[wq_waddr] <= pid_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign must_block_o  = res_q.must_block;
  assign wake_valid_o  = res_q.wake_valid;
  assign wake_pid_o    = res_q.wake_pid;
  assign count_value_o = res_q.count_value;
  assign last_o        = res_q.last;

  // Only the wake beats of a close come before the final beat of a request.
  `CST_ASSERT_SAME(a_nonlast_is_wake, out_valid_o && !last_o, wake_valid_o, "non-final beat without a wake")
  // The close walk never runs with no waiter left to read.
  `CST_ASSERT_SAME(a_walk_has_waiter, state_q == S_WALK, walk_left_q != '0, "close walk with empty queue")
  // A queued waiter always comes with an update of the entry's fill.
  `CST_ASSERT_SAME(a_enqueue_updates_fill, wq_we, tab_we && (state_q == S_LOOK), "enqueue without entry write")
  // An accepted request is looked up in the following cycle.
  `CST_ASSERT_NEXT(a_accept_to_lookup, in_acc, state_q == S_LOOK, "request not looked up after accept")

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the counting semaphore table: random and directed requests.
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned SEMS        = cst_pkg::NUM_SEMS_DEF;
  localparam int unsigned DEPTH       = cst_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned RAND_ITEMS  = 145;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_WAIT  = 20;

  // Codes above read count are reserved and must be rejected.
  localparam logic [cst_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [cst_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [cst_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct {
    logic [cst_pkg::OP_W-1:0]    op;
    logic [cst_pkg::ID_W-1:0]    id;
    logic [cst_pkg::COUNT_W-1:0] init;
    logic [cst_pkg::PID_W-1:0]   pid;
  } sem_req_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [cst_pkg::OP_W-1:0]    operation = '0;
  logic [cst_pkg::ID_W-1:0]    sem_id = '0;
  logic [cst_pkg::COUNT_W-1:0] init_count = '0;
  logic [cst_pkg::PID_W-1:0]   caller_pid = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  status;
  logic                        must_block;
  logic                        wake_valid;
  logic [cst_pkg::PID_W-1:0]   wake_pid;
  logic [cst_pkg::COUNT_W-1:0] count_value;
  logic                        last;

  counting_semaphore_table_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (operation),
    .sem_id_i     (sem_id),
    .init_count_i (init_count),
    .caller_pid_i (caller_pid),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .must_block_o (must_block),
    .wake_valid_o (wake_valid),
    .wake_pid_o   (wake_pid),
    .count_value_o(count_value),
    .last_o       (last)
  );

  always #5 clk = ~clk;

  sem_req_t          req_fifo[$];
  sem_req_t          cur_req;
  cst_pkg::result_t  results_due[$];
  int unsigned reqs_taken = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Shadow copy of the semaphore table.
  bit           shadow_open[SEMS];
  int unsigned  sem_count[SEMS];
  int unsigned  wq_head[SEMS];
  int unsigned  wq_fill[SEMS];
  logic [cst_pkg::PID_W-1:0] wq_pids[SEMS*DEPTH];

  function automatic void push_result(cst_pkg::status_e st, logic blk, logic wv,
                                      logic [cst_pkg::PID_W-1:0] pid, int unsigned cnt,
                                      logic lst);
    cst_pkg::result_t r;
    r.status      = st;
    r.must_block  = blk;
    r.wake_valid  = wv;
    r.wake_pid    = pid;
    r.count_value = cnt[cst_pkg::COUNT_W-1:0];
    r.last        = lst;
    results_due.push_back(r);
  endfunction

  function automatic logic [cst_pkg::PID_W-1:0] pop_waiter(int unsigned id);
    logic [cst_pkg::PID_W-1:0] w;
    w = wq_pids[id*DEPTH + wq_head[id]];
    wq_head[id] = (wq_head[id] + 1) % DEPTH;
    wq_fill[id] = wq_fill[id] - 1;
    return w;
  endfunction

  function automatic void predict_semaphore(sem_req_t rq);
    int unsigned id;
    id = rq.id;
    if (rq.op > cst_pkg::OP_READ || id == 0 || id >= SEMS) begin
      push_result(cst_pkg::ST_BAD, 1'b0, 1'b0, '0, 0, 1'b1);
      return;
    end
    if (rq.op == cst_pkg::OP_OPEN) begin
      if (shadow_open[id]) begin
        push_result(cst_pkg::ST_ALREADY, 1'b0, 1'b0, '0, sem_count[id], 1'b1);
      end else begin
        shadow_open[id] = 1'b1;
        sem_count[id]   = rq.init;
        wq_head[id]     = 0;
        wq_fill[id]     = 0;
        push_result(cst_pkg::ST_OK, 1'b0, 1'b0, '0, sem_count[id], 1'b1);
      end
      return;
    end
    if (!shadow_open[id]) begin
      push_result(cst_pkg::ST_BAD, 1'b0, 1'b0, '0, 0, 1'b1);
      return;
    end
    case (rq.op)
      cst_pkg::OP_CLOSE: begin
        while (wq_fill[id] != 0)
          push_result(cst_pkg::ST_OK, 1'b0, 1'b1, pop_waiter(id), 0, 1'b0);
        shadow_open[id] = 1'b0;
        sem_count[id]   = 0;
        wq_head[id]     = 0;
        wq_fill[id]     = 0;
        push_result(cst_pkg::ST_OK, 1'b0, 1'b0, '0, 0, 1'b1);
      end
      cst_pkg::OP_POST: begin
        if (wq_fill[id] != 0) begin
          push_result(cst_pkg::ST_OK, 1'b0, 1'b1, pop_waiter(id), sem_count[id], 1'b1);
        end else begin
          if (sem_count[id] < cst_pkg::COUNT_MAX) sem_count[id]++;
          push_result(cst_pkg::ST_OK, 1'b0, 1'b0, '0, sem_count[id], 1'b1);
        end
      end
      cst_pkg::OP_WAIT: begin
        if (sem_count[id] != 0) begin
          sem_count[id]--;
          push_result(cst_pkg::ST_OK, 1'b0, 1'b0, '0, sem_count[id], 1'b1);
        end else if (wq_fill[id] >= DEPTH) begin
          push_result(cst_pkg::ST_FULL, 1'b0, 1'b0, '0, 0, 1'b1);
        end else begin
          wq_pids[id*DEPTH + (wq_head[id] + wq_fill[id]) % DEPTH] = rq.pid;
          wq_fill[id]++;
          push_result(cst_pkg::ST_OK, 1'b1, 1'b0, '0, 0, 1'b1);
        end
      end
      default: push_result(cst_pkg::ST_OK, 1'b0, 1'b0, '0, sem_count[id], 1'b1);
    endcase
  endfunction

  // A window in the middle of the run where neither side idles.
  function automatic bit calm_window();
    return reqs_taken >= 90 && reqs_taken < 140;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Request driver.
  always @(posedge clk or negedge rst_n) begin : drv
    sem_req_t nxt;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      operation  <= '0;
      sem_id     <= '0;
      init_count <= '0;
      caller_pid <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_semaphore(cur_req);
        reqs_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (req_fifo.size() != 0 && (calm_window() || $urandom_range(0, 99) >= 10)) begin
          nxt        = req_fifo.pop_front();
          cur_req    = nxt;
          operation  <= nxt.op;
          sem_id     <= nxt.id;
          init_count <= nxt.init;
          caller_pid <= nxt.pid;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk or negedge rst_n) begin : mon
    cst_pkg::result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result beat, status %0d wake_pid %0d count %0d",
                   $time, status, wake_pid, count_value);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("must_block", 32'(want.must_block), 32'(must_block));
          check_field("wake_valid", 32'(want.wake_valid), 32'(wake_valid));
          check_field("wake_pid", 32'(want.wake_pid), 32'(wake_pid));
          check_field("count_value", 32'(want.count_value), 32'(count_value));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      out_stall <= !calm_window() && $urandom_range(0, 99) < 10;
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_req(logic [cst_pkg::OP_W-1:0] op, logic [cst_pkg::ID_W-1:0] id,
                         logic [cst_pkg::COUNT_W-1:0] init, logic [cst_pkg::PID_W-1:0] pid);
    sem_req_t rq;
    rq.op   = op;
    rq.id   = id;
    rq.init = init;
    rq.pid  = pid;
    req_fifo.push_back(rq);
  endtask

  function automatic logic [cst_pkg::ID_W-1:0] pick_id();
    logic [cst_pkg::ID_W-1:0] pool[5] = '{5'd1, 5'd2, 5'd16, 5'd30, 5'd31};
    if ($urandom_range(0, 99) < 10) return cst_pkg::ID_W'($urandom_range(0, 31));
    return pool[$urandom_range(0, 4)];
  endfunction

  function automatic logic [cst_pkg::COUNT_W-1:0] pick_init();
    if ($urandom_range(0, 99) < 40) return '0;
    return cst_pkg::COUNT_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [cst_pkg::PID_W-1:0] pick_pid();
    return cst_pkg::PID_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [cst_pkg::OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return cst_pkg::OP_OPEN;
    if (r < 20) return cst_pkg::OP_CLOSE;
    if (r < 45) return cst_pkg::OP_POST;
    if (r < 80) return cst_pkg::OP_WAIT;
    if (r < 92) return cst_pkg::OP_READ;
    case ($urandom_range(0, 2))
      0:       return OP_RSVD5;
      1:       return OP_RSVD6;
      default: return OP_RSVD7;
    endcase
  endfunction

  task automatic wait_drained();
    while (req_fifo.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stim
    int unsigned made;
    int unsigned n;
    logic [cst_pkg::ID_W-1:0] id;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Bad ids, reserved codes and entries that are not open.
    add_req(cst_pkg::OP_OPEN, 5'd0, 7'd5, 16'd1);
    add_req(cst_pkg::OP_READ, 5'd31, 7'd0, 16'd0);
    add_req(cst_pkg::OP_POST, 5'd5, 7'd0, 16'd0);
    add_req(OP_RSVD5, 5'd1, 7'd0, 16'd0);
    add_req(OP_RSVD6, 5'd31, 7'd127, 16'hFFFF);
    add_req(OP_RSVD7, 5'd2, 7'd0, 16'd0);
    // Saturation at the top of the count, and a second open of the same entry.
    add_req(cst_pkg::OP_OPEN, 5'd31, 7'd127, 16'd0);
    add_req(cst_pkg::OP_POST, 5'd31, 7'd0, 16'd0);
    add_req(cst_pkg::OP_OPEN, 5'd31, 7'd0, 16'd0);
    add_req(cst_pkg::OP_WAIT, 5'd31, 7'd0, 16'h1234);
    add_req(cst_pkg::OP_READ, 5'd31, 7'd0, 16'd0);
    // Waiters queued, one woken by a post, the rest by close.
    add_req(cst_pkg::OP_OPEN, 5'd1, 7'd0, 16'd0);
    add_req(cst_pkg::OP_WAIT, 5'd1, 7'd0, 16'hFFFF);
    add_req(cst_pkg::OP_WAIT, 5'd1, 7'd0, 16'h0000);
    add_req(cst_pkg::OP_WAIT, 5'd1, 7'd0, 16'hA5C3);
    add_req(cst_pkg::OP_POST, 5'd1, 7'd0, 16'd0);
    add_req(cst_pkg::OP_READ, 5'd1, 7'd0, 16'd0);
    add_req(cst_pkg::OP_CLOSE, 5'd1, 7'd0, 16'd0);
    add_req(cst_pkg::OP_WAIT, 5'd1, 7'd0, 16'd7);
    add_req(cst_pkg::OP_CLOSE, 5'd31, 7'd0, 16'd0);
    add_req(cst_pkg::OP_OPEN, 5'd30, 7'd1, 16'd0);
    add_req(cst_pkg::OP_WAIT, 5'd30, 7'd0, 16'h5A3C);
    add_req(cst_pkg::OP_WAIT, 5'd30, 7'd0, 16'hC3A5);
    add_req(cst_pkg::OP_POST, 5'd30, 7'd0, 16'd0);
    add_req(cst_pkg::OP_POST, 5'd30, 7'd0, 16'd0);

    // Hold the sender back until the table has answered everything.
    wait_drained();

    made = 0;
    while (made < RAND_ITEMS) begin
      if ($urandom_range(0, 99) < 8) begin
        // Fill one queue past its depth, wake a few, then close it.
        id = pick_id();
        add_req(cst_pkg::OP_CLOSE, id, 7'd0, 16'd0);
        add_req(cst_pkg::OP_OPEN, id, 7'd0, 16'd0);
        n = DEPTH + 1 + $urandom_range(0, 2);
        repeat (n) add_req(cst_pkg::OP_WAIT, id, pick_init(), pick_pid());
        repeat ($urandom_range(0, 3)) add_req(cst_pkg::OP_POST, id, 7'd0, 16'd0);
        add_req(cst_pkg::OP_CLOSE, id, 7'd0, 16'd0);
        made += n + 3;
      end else begin
        add_req(pick_op(), pick_id(), pick_init(), pick_pid());
        made++;
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
